// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

  // Fixed register file layout: four partitions, size then count
  localparam int CFG_PARTS = 4;
  localparam int PART_W    = 2;
  localparam int SIZE_W    = 8;
  localparam int COUNT_W   = 6;
  localparam int BLOCK_W   = 5;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int ACT_W     = 7;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOBLOCK  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Register index: low bit selects size or count, upper bits the partition
  localparam logic REG_SEL_SIZE  = 1'b0;
  localparam logic REG_SEL_COUNT = 1'b1;

  // Reallocate compares against the old block size less this fixed slack
  localparam logic [SIZE_W-1:0] REALLOC_SLACK = 8'd2;
  localparam logic [SIZE_W-1:0] NO_OLD_SIZE   = 8'd255;

  typedef struct packed {
    logic              present;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } part_info_t;

endpackage

// ===== design/fbpa_cfg.sv =====
module fbpa_cfg #(
  parameter int NUM_PARTITIONS = 4,
  parameter int MAX_BLOCKS     = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::SIZE_W-1:0]         cfg_data,
  output fbpa_pkg::part_info_t                info [fbpa_pkg::CFG_PARTS],
  output logic [fbpa_pkg::SIZE_W-1:0]         largest
);

  logic [fbpa_pkg::SIZE_W-1:0]  size  [fbpa_pkg::CFG_PARTS];
  logic [fbpa_pkg::COUNT_W-1:0] count [fbpa_pkg::CFG_PARTS];
  logic [fbpa_pkg::PART_W-1:0]  wr_part;

  assign wr_part = cfg_index[fbpa_pkg::CFG_IDX_W-1:1];

  // Hold the partition registers; write size or count by index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
        size[p]  <= '0;
        count[p] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index[0] == fbpa_pkg::REG_SEL_SIZE) begin
        size[wr_part] <= cfg_data;
      end else begin
        count[wr_part] <= cfg_data[fbpa_pkg::COUNT_W-1:0];
      end
    end
  end

  // Mark a partition present when in range, sized and not over-counted
  always_comb begin
    for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
      info[p].size    = size[p];
      info[p].count   = count[p];
      info[p].present = (p < NUM_PARTITIONS) && (size[p] != '0) &&
                        ({1'b0, count[p]} <= (fbpa_pkg::COUNT_W+1)'(MAX_BLOCKS));
    end
  end

  // Take the largest block size over present partitions
  always_comb begin
    largest = '0;
    for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
      if (info[p].present && (size[p] > largest)) begin
        largest = size[p];
      end
    end
  end

endmodule

// ===== design/fbpa_scan.sv =====
module fbpa_scan #(
  parameter int MAX_BLOCKS  = 32,
  parameter int GUARD_BYTES = 2,
  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  fbpa_pkg::part_info_t         info,
  input  logic [MAX_BLOCKS-1:0]        map_word,
  input  logic [fbpa_pkg::SIZE_W-1:0]  req_size,
  output logic                         hit,
  output logic [BW-1:0]                idx
);

  logic          fit;
  logic          any_free;
  logic [BW-1:0] low_free;

  // Skip blocks too small once the guard bytes are added
  assign fit = info.present &&
               (({1'b0, req_size} + (fbpa_pkg::SIZE_W+1)'(GUARD_BYTES)) <=
                {1'b0, info.size});

  // Find the lowest free block below the partition's count
  always_comb begin
    any_free = 1'b0;
    low_free = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (!map_word[b] && ((fbpa_pkg::COUNT_W+1)'(b) < {1'b0, info.count})) begin
        any_free = 1'b1;
        low_free = BW'(b);
      end
    end
  end

  assign hit = fit && any_free;
  assign idx = low_free;

endmodule

// ===== design/fixed_block_partition_allocator.sv =====
// Fixed-size block pool allocator over four configurable partitions.
//
// Configuration: write cfg_data to register cfg_index with cfg_we while the
// block is idle. Index 2p sets the block size of partition p, index 2p+1
// its block count. A partition with size zero is unused.
// Commands: raise start with command, request_size and the handle fields
// while busy is low; the beat is taken at that edge. Allocate grants the
// lowest free block of the first fitting partition, free releases a handle,
// reallocate allocates anew, then frees the old handle; size zero only frees.
// Results: done is high for exactly one cycle with status and the grant
// fields; the receiver cannot stall, so a result is never held back.
// Sequencing: the shared scan unit looks at one partition per cycle. A
// rejected request registers done straight from the accepted beat. Allocate
// scans the partitions in order and registers done at the first hit or after
// the last partition; reallocate adds a free step for the old block after a
// grant, and free runs only the free step. busy stays high while an item is
// at work, so no new beat is taken before done; one may start in that cycle.
// Reset clears the configuration, all in-use maps and active counts at once.
module fixed_block_partition_allocator #(
  parameter int NUM_PARTITIONS = 4,
  parameter int MAX_BLOCKS     = 32,
  parameter int GUARD_BYTES    = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [fbpa_pkg::CMD_W-1:0]         command,
  input  logic [fbpa_pkg::SIZE_W-1:0]        request_size,
  input  logic [fbpa_pkg::PART_W-1:0]        handle_partition,
  input  logic [fbpa_pkg::BLOCK_W-1:0]       handle_block,
  output logic                               done,
  output logic [fbpa_pkg::STATUS_W-1:0]      status,
  output logic                               grant_valid,
  output logic [fbpa_pkg::PART_W-1:0]        grant_partition,
  output logic [fbpa_pkg::BLOCK_W-1:0]       grant_block
);

  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FREE} state_t;

  state_t                         state;
  fbpa_pkg::part_info_t           info [fbpa_pkg::CFG_PARTS];
  logic [fbpa_pkg::SIZE_W-1:0]    largest;
  logic [MAX_BLOCKS-1:0]          map [fbpa_pkg::CFG_PARTS];
  logic [fbpa_pkg::ACT_W-1:0]     act [fbpa_pkg::CFG_PARTS];

  logic [fbpa_pkg::CMD_W-1:0]     cmd_r;
  logic [fbpa_pkg::SIZE_W-1:0]    size_r;
  logic [fbpa_pkg::PART_W-1:0]    hp_r;
  logic [fbpa_pkg::BLOCK_W-1:0]   hb_r;
  logic [fbpa_pkg::PART_W-1:0]    pidx;

  logic                           accept;
  logic                           in_found;
  logic [fbpa_pkg::SIZE_W-1:0]    old_size;
  logic [fbpa_pkg::PART_W-1:0]    rd_part;
  logic [MAX_BLOCKS-1:0]          map_word;
  logic                           scan_hit;
  logic [BW-1:0]                  scan_idx;
  logic                           free_found;
  logic [BW-1:0]                  hb_idx;

  fbpa_cfg #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .MAX_BLOCKS     (MAX_BLOCKS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info),
    .largest   (largest)
  );

  // Read one partition map: the old handle's while freeing, else the scan's
  assign rd_part  = (state == S_FREE) ? hp_r : pidx;
  assign map_word = map[rd_part];

  fbpa_scan #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .GUARD_BYTES (GUARD_BYTES)
  ) u_scan (
    .info     (info[pidx]),
    .map_word (map_word),
    .req_size (size_r),
    .hit      (scan_hit),
    .idx      (scan_idx)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Look up the incoming handle to get the old block size for reallocate
  assign in_found = info[handle_partition].present &&
                    ({1'b0, handle_block} < info[handle_partition].count);
  assign old_size = in_found ? (info[handle_partition].size - fbpa_pkg::REALLOC_SLACK)
                             : fbpa_pkg::NO_OLD_SIZE;

  // Look up the held handle for the free step
  assign free_found = info[hp_r].present && ({1'b0, hb_r} < info[hp_r].count);
  assign hb_idx     = BW'(hb_r);

  // Sequence accept, partition scan and free; register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pidx  <= '0;
      for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
        map[p] <= '0;
        act[p] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r           <= command;
            size_r          <= request_size;
            hp_r            <= handle_partition;
            hb_r            <= handle_block;
            pidx            <= '0;
            grant_valid     <= 1'b0;
            grant_partition <= '0;
            grant_block     <= '0;
            case (command)
              fbpa_pkg::CMD_ALLOC: begin
                if (request_size > largest) begin
                  status <= fbpa_pkg::ST_INVALID;
                  done   <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              fbpa_pkg::CMD_FREE: begin
                state <= S_FREE;
              end
              fbpa_pkg::CMD_REALLOC: begin
                if (request_size == '0) begin
                  state <= S_FREE;
                end else if ((request_size > largest) || (request_size == old_size)) begin
                  status <= fbpa_pkg::ST_INVALID;
                  done   <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                status <= fbpa_pkg::ST_INVALID;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            map[pidx][scan_idx] <= 1'b1;
            act[pidx]           <= act[pidx] + 1'b1;
            grant_valid         <= 1'b1;
            grant_partition     <= pidx;
            grant_block         <= fbpa_pkg::BLOCK_W'(scan_idx);
            if (cmd_r == fbpa_pkg::CMD_REALLOC) begin
              state <= S_FREE;
            end else begin
              status <= fbpa_pkg::ST_OK;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else if (pidx == fbpa_pkg::PART_W'(fbpa_pkg::CFG_PARTS - 1)) begin
            status <= fbpa_pkg::ST_NOBLOCK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            pidx <= pidx + 1'b1;
          end
        end
        S_FREE: begin
          if (!free_found) begin
            status <= fbpa_pkg::ST_NOTFOUND;
          end else begin
            status <= fbpa_pkg::ST_OK;
            if (map_word[hb_idx]) begin
              map[hp_r][hb_idx] <= 1'b0;
              if (act[hp_r] != '0) begin
                act[hp_r] <= act[hp_r] - 1'b1;
              end
            end
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat only follows an item that was at work or just accepted
  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(accept))
    else $error("result beat without an item in flight");

  // An accepted item keeps the block busy or delivers its beat at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted item neither in progress nor finished");

  // A result without a grant carries zero grant fields
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !grant_valid) |-> (grant_partition == '0) && (grant_block == '0))
    else $error("grant fields set without a grant");

  // A granted block lies in a present partition, below its count
  a_grant_present: assert property (@(posedge clk) disable iff (rst)
    (done && grant_valid) |-> info[grant_partition].present &&
                              ({1'b0, grant_block} < info[grant_partition].count))
    else $error("grant outside a present partition");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int GUARD         = 2;
  localparam int MAX_BLK       = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // Command code the block does not define; it must answer with the invalid status
  localparam logic [fbpa_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

  typedef struct packed {
    logic [fbpa_pkg::CMD_W-1:0]   cmd;
    logic [fbpa_pkg::SIZE_W-1:0]  size;
    logic [fbpa_pkg::PART_W-1:0]  part;
    logic [fbpa_pkg::BLOCK_W-1:0] blk;
  } alloc_req_t;

  typedef struct packed {
    logic [fbpa_pkg::STATUS_W-1:0] st;
    logic                          grant;
    logic [fbpa_pkg::PART_W-1:0]   gpart;
    logic [fbpa_pkg::BLOCK_W-1:0]  gblk;
  } alloc_rsp_t;

  // Predicts grants and status from its own copy of the pool state
  class alloc_scoreboard;
    logic [fbpa_pkg::SIZE_W-1:0]  part_size  [fbpa_pkg::CFG_PARTS];
    logic [fbpa_pkg::COUNT_W-1:0] part_count [fbpa_pkg::CFG_PARTS];
    logic [MAX_BLK-1:0]           used_map   [fbpa_pkg::CFG_PARTS];
    alloc_rsp_t                   expected_q [$];
    int                           errors;

    function new();
      for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
        part_size[p]  = '0;
        part_count[p] = '0;
        used_map[p]   = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                            logic [fbpa_pkg::SIZE_W-1:0] data);
      int p;
      p = int'(idx[fbpa_pkg::CFG_IDX_W-1:1]);
      if (idx[0] == fbpa_pkg::REG_SEL_SIZE) begin
        part_size[p] = data;
      end else begin
        part_count[p] = data[fbpa_pkg::COUNT_W-1:0];
      end
    endfunction

    function bit present(int p);
      return p < fbpa_pkg::CFG_PARTS && part_size[p] != 0 && part_count[p] <= MAX_BLK;
    endfunction

    function int largest();
      int m;
      m = 0;
      for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++)
        if (present(p) && part_size[p] > m) m = int'(part_size[p]);
      return m;
    endfunction

    function bit found(int p, int b);
      return present(p) && b < part_count[p];
    endfunction

    // First fitting partition, lowest free block
    function logic [fbpa_pkg::STATUS_W-1:0] take_block(int req, output int gp,
                                                       output int gb);
      gp = 0;
      gb = 0;
      if (req > largest()) return fbpa_pkg::ST_INVALID;
      for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
        if (!present(p)) continue;
        if (req + GUARD > part_size[p]) continue;
        for (int b = 0; b < part_count[p]; b++) begin
          if (!used_map[p][b]) begin
            used_map[p][b] = 1'b1;
            gp = p;
            gb = b;
            return fbpa_pkg::ST_OK;
          end
        end
      end
      return fbpa_pkg::ST_NOBLOCK;
    endfunction

    // Freeing a block that is already free still answers ok
    function logic [fbpa_pkg::STATUS_W-1:0] release_block(int p, int b);
      if (!found(p, b)) return fbpa_pkg::ST_NOTFOUND;
      used_map[p][b] = 1'b0;
      return fbpa_pkg::ST_OK;
    endfunction

    function void note(alloc_req_t r);
      alloc_rsp_t                    e;
      int                            gp, gb;
      logic [fbpa_pkg::SIZE_W-1:0]   old_size;
      logic [fbpa_pkg::STATUS_W-1:0] st;
      e  = '0;
      gp = 0;
      gb = 0;
      case (r.cmd)
        fbpa_pkg::CMD_ALLOC: begin
          e.st    = take_block(int'(r.size), gp, gb);
          e.grant = (e.st == fbpa_pkg::ST_OK);
        end
        fbpa_pkg::CMD_FREE: begin
          e.st = release_block(int'(r.part), int'(r.blk));
        end
        fbpa_pkg::CMD_REALLOC: begin
          old_size = found(int'(r.part), int'(r.blk)) ?
                     part_size[r.part] - fbpa_pkg::REALLOC_SLACK : fbpa_pkg::NO_OLD_SIZE;
          if (r.size == 0) begin
            e.st = release_block(int'(r.part), int'(r.blk));
          end else if (r.size > largest() || r.size == old_size) begin
            e.st = fbpa_pkg::ST_INVALID;
          end else begin
            // Allocate first; free the old handle only on a grant
            st = take_block(int'(r.size), gp, gb);
            if (st == fbpa_pkg::ST_OK) begin
              e.grant = 1'b1;
              e.st    = release_block(int'(r.part), int'(r.blk));
            end else begin
              e.st = st;
            end
          end
        end
        default: begin
          e.st = fbpa_pkg::ST_INVALID;
        end
      endcase
      if (e.grant) begin
        e.gpart = gp[fbpa_pkg::PART_W-1:0];
        e.gblk  = gb[fbpa_pkg::BLOCK_W-1:0];
      end
      expected_q.push_back(e);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Choose a block currently held, if any
    function bit pick_used(output int p, output int b);
      int cand_p [$];
      int cand_b [$];
      int k;
      p = 0;
      b = 0;
      for (int i = 0; i < fbpa_pkg::CFG_PARTS; i++)
        if (present(i))
          for (int j = 0; j < part_count[i]; j++)
            if (used_map[i][j]) begin
              cand_p.push_back(i);
              cand_b.push_back(j);
            end
      if (cand_p.size() == 0) return 1'b0;
      k = $urandom_range(0, cand_p.size() - 1);
      p = cand_p[k];
      b = cand_b[k];
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(alloc_rsp_t got);
      alloc_rsp_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: st=%0d grant=%0d p=%0d b=%0d",
                                  got.st, got.grant, got.gpart, got.gblk));
        return;
      end
      e = expected_q.pop_front();
      if (got !== e)
        report_mismatch($sformatf("st=%0d/%0d grant=%0d/%0d p=%0d/%0d b=%0d/%0d (got/exp)",
                                  got.st, e.st, got.grant, e.grant, got.gpart, e.gpart,
                                  got.gblk, e.gblk));
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [fbpa_pkg::SIZE_W-1:0]       cfg_data = '0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [fbpa_pkg::CMD_W-1:0]        command = fbpa_pkg::CMD_ALLOC;
  logic [fbpa_pkg::SIZE_W-1:0]       request_size = '0;
  logic [fbpa_pkg::PART_W-1:0]       handle_partition = '0;
  logic [fbpa_pkg::BLOCK_W-1:0]      handle_block = '0;
  logic                              done;
  logic [fbpa_pkg::STATUS_W-1:0]     status;
  logic                              grant_valid;
  logic [fbpa_pkg::PART_W-1:0]       grant_partition;
  logic [fbpa_pkg::BLOCK_W-1:0]      grant_block;

  logic [fbpa_pkg::SIZE_W-1:0]       plan_size  [fbpa_pkg::CFG_PARTS];
  logic [fbpa_pkg::SIZE_W-1:0]       plan_count [fbpa_pkg::CFG_PARTS];
  int                                cycle_count = 0;
  alloc_scoreboard                   sb;

  fixed_block_partition_allocator dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .request_size    (request_size),
    .handle_partition(handle_partition),
    .handle_block    (handle_block),
    .done            (done),
    .status          (status),
    .grant_valid     (grant_valid),
    .grant_partition (grant_partition),
    .grant_block     (grant_block)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    alloc_rsp_t got;
    if (!rst && done === 1'b1) begin
      got = {status, grant_valid, grant_partition, grant_block};
      sb.check(got);
    end
  end

  // Hold the beat until busy is low at an edge, then predict it
  task automatic drive_req(input alloc_req_t r);
    start            <= 1'b1;
    command          <= r.cmd;
    request_size     <= r.size;
    handle_partition <= r.part;
    handle_block     <= r.blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(r);
  endtask

  task automatic send(logic [fbpa_pkg::CMD_W-1:0] cmd, int size, int part, int blk);
    alloc_req_t r;
    r.cmd  = cmd;
    r.size = size[fbpa_pkg::SIZE_W-1:0];
    r.part = part[fbpa_pkg::PART_W-1:0];
    r.blk  = blk[fbpa_pkg::BLOCK_W-1:0];
    drive_req(r);
  endtask

  // Wait out every pending result, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back from the plan
  task automatic apply_setting();
    logic [fbpa_pkg::CFG_IDX_W-1:0] idx;
    logic [fbpa_pkg::SIZE_W-1:0]    data;
    for (int i = 0; i < 2 * fbpa_pkg::CFG_PARTS; i++) begin
      idx  = i[fbpa_pkg::CFG_IDX_W-1:0];
      data = (idx[0] == fbpa_pkg::REG_SEL_SIZE) ? plan_size[i >> 1] : plan_count[i >> 1];
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      sb.write_reg(idx, data);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_plan(int p, int size, int count);
    plan_size[p]  = size[fbpa_pkg::SIZE_W-1:0];
    plan_count[p] = count[fbpa_pkg::SIZE_W-1:0];
  endtask

  task automatic randomize_plan();
    int size, count;
    for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) begin
      case ($urandom_range(0, 7))
        0:       size = 0;
        1:       size = $urandom_range(1, 2);
        2:       size = 255;
        3:       size = $urandom_range(65, 254);
        default: size = $urandom_range(3, 64);
      endcase
      case ($urandom_range(0, 7))
        0:       count = 0;
        1:       count = MAX_BLK;
        2:       count = $urandom_range(MAX_BLK + 1, 63);
        default: count = $urandom_range(1, 8);
      endcase
      // Upper data bits of a count write are don't-care
      set_plan(p, size, count | ($urandom_range(0, 3) << fbpa_pkg::COUNT_W));
    end
  endtask

  // Sizes cluster around the configured block sizes to hit the fit boundary
  function automatic logic [fbpa_pkg::SIZE_W-1:0] pick_size();
    logic [fbpa_pkg::SIZE_W-1:0] base;
    base = sb.part_size[$urandom_range(0, fbpa_pkg::CFG_PARTS - 1)];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 8'd255;
      2, 3:    return base - 8'd2;
      4:       return base - 8'd1;
      5:       return fbpa_pkg::SIZE_W'($urandom_range(0, 255));
      default: return fbpa_pkg::SIZE_W'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic pick_handle(inout alloc_req_t r);
    int p, b;
    if ($urandom_range(0, 3) != 0 && sb.pick_used(p, b)) begin
      r.part = p[fbpa_pkg::PART_W-1:0];
      r.blk  = b[fbpa_pkg::BLOCK_W-1:0];
    end else if ($urandom_range(0, 1) != 0) begin
      r.blk = fbpa_pkg::BLOCK_W'($urandom_range(0, 9));
    end
  endtask

  // Mostly valid traffic on live handles, some raw noise
  task automatic make_req(output alloc_req_t r);
    int roll;
    r.size = fbpa_pkg::SIZE_W'($urandom_range(0, 255));
    r.part = fbpa_pkg::PART_W'($urandom_range(0, 3));
    r.blk  = fbpa_pkg::BLOCK_W'($urandom_range(0, 31));
    roll   = $urandom_range(0, 99);
    if (roll < 45) begin
      r.cmd  = fbpa_pkg::CMD_ALLOC;
      r.size = pick_size();
    end else if (roll < 75) begin
      r.cmd = fbpa_pkg::CMD_FREE;
      pick_handle(r);
    end else if (roll < 95) begin
      r.cmd  = fbpa_pkg::CMD_REALLOC;
      r.size = ($urandom_range(0, 9) == 0) ? '0 : pick_size();
      pick_handle(r);
    end else begin
      r.cmd = fbpa_pkg::CMD_W'($urandom_range(0, 3));
    end
  endtask

  // Bursts of random length, random gaps between them
  task automatic random_phase(int n);
    int         sent, burst, gap;
    alloc_req_t r;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < n; i++) begin
        make_req(r);
        drive_req(r);
        sent++;
      end
      start <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: no partition present
    send(fbpa_pkg::CMD_ALLOC, 0, 0, 0);
    send(fbpa_pkg::CMD_FREE, 0, 0, 0);
    drain();

    // Mixed partitions, including one too small to ever fit
    set_plan(0, 10, 4);
    set_plan(1, 40, 2);
    set_plan(2, 255, 32);
    set_plan(3, 1, 3);
    apply_setting();
    send(fbpa_pkg::CMD_ALLOC, 0, 0, 0);
    send(fbpa_pkg::CMD_ALLOC, 8, 0, 0);        // exact fit with guard
    send(fbpa_pkg::CMD_ALLOC, 9, 0, 0);        // spills to next partition
    send(fbpa_pkg::CMD_ALLOC, 255, 0, 0);      // at largest size but guard does not fit
    send(fbpa_pkg::CMD_ALLOC, 253, 0, 0);
    send(fbpa_pkg::CMD_FREE, 0, 1, 0);
    send(fbpa_pkg::CMD_FREE, 0, 1, 0);         // already free
    send(fbpa_pkg::CMD_FREE, 0, 0, 4);         // index past count
    send(fbpa_pkg::CMD_FREE, 0, 3, 0);
    send(fbpa_pkg::CMD_REALLOC, 0, 0, 0);      // size zero frees
    send(fbpa_pkg::CMD_REALLOC, 8, 0, 2);      // same as old size
    send(fbpa_pkg::CMD_REALLOC, 38, 1, 0);
    send(fbpa_pkg::CMD_REALLOC, 20, 1, 0);
    send(fbpa_pkg::CMD_REALLOC, 255, 3, 0);    // old size wraps to 255
    send(fbpa_pkg::CMD_REALLOC, 5, 2, 31);
    send(fbpa_pkg::CMD_REALLOC, 5, 1, 7);      // grant, then old handle not found
    send(CMD_RESERVED, 255, 3, 31);
    send(fbpa_pkg::CMD_ALLOC, 30, 0, 0);
    send(fbpa_pkg::CMD_ALLOC, 30, 0, 0);       // takes the next free block of the same partition
    send(fbpa_pkg::CMD_FREE, 0, 3, 31);
    drain();

    // Every partition absent: zero size or count over the limit
    set_plan(0, 0, 5);
    set_plan(1, 200, 40);
    set_plan(2, 0, 0);
    set_plan(3, 255, 8'hFF);
    apply_setting();
    send(fbpa_pkg::CMD_ALLOC, 0, 0, 0);
    send(fbpa_pkg::CMD_ALLOC, 1, 0, 0);
    send(fbpa_pkg::CMD_REALLOC, 0, 1, 0);
    send(fbpa_pkg::CMD_FREE, 0, 0, 0);
    drain();

    // Largest sizes and counts everywhere
    for (int p = 0; p < fbpa_pkg::CFG_PARTS; p++) set_plan(p, 255, MAX_BLK);
    apply_setting();
    random_phase(60);
    drain();

    for (int k = 0; k < 7; k++) begin
      randomize_plan();
      apply_setting();
      random_phase(65);
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fbpa_pkg.sv
design/fbpa_cfg.sv
design/fbpa_scan.sv
design/fixed_block_partition_allocator.sv
tb/tb.sv
